// ===== hw/rtl/sprs_pkg.sv =====
package sprs_pkg;

   localparam int RailCount = 11;

   // Sequence stage codes
   localparam logic [3:0] STAGE_IDLE       = 4'd0;
   localparam logic [3:0] STAGE_ON_FIRST   = 4'd1;
   localparam logic [3:0] STAGE_ON_EARLY   = 4'd2;
   localparam logic [3:0] STAGE_ON_LAST    = 4'd5;
   localparam logic [3:0] STAGE_OFF_FIRST  = 4'd6;
   localparam logic [3:0] STAGE_RESET_HOLD = 4'd9;
   localparam logic [3:0] STAGE_OFF_LAST   = 4'd11;

   // Register indexes on the control port (selected by paddr[2])
   localparam logic REG_CHECK_DELAY = 1'b0;
   localparam logic REG_BOARD_ID    = 1'b1;

   localparam logic [15:0] CHECK_DELAY_RESET = 16'd100;
   localparam logic [7:0]  BOARD_ID_RESET    = 8'd0;

   typedef struct packed {
      logic [15:0] check_delay_ticks;
      logic [7:0]  board_identity;
   } cfg_type;

   typedef struct packed {
      logic                 host_power_enable;
      logic                 evaluate;
      logic [RailCount-1:0] power_good;
   } item_type;

   typedef struct packed {
      logic [RailCount-1:0] rail_enables;
      logic                 osc_enable;
      logic                 reset_hold;
      logic                 card_power_ok;
      logic                 busy_res;
      logic [3:0]           sequence_stage;
      logic                 fault_valid;
      logic                 fault_during_off;
      logic [3:0]           fault_rail;
      logic [7:0]           fault_board;
   } result_type;

   // Rails switched and checked by each stage.
   function automatic logic [RailCount-1:0] stage_rails(input logic [3:0] stage);
      logic [RailCount-1:0] rails;
      unique case (stage)
         4'd1, 4'd10: rails = 11'h007;
         4'd2, 4'd9:  rails = 11'h018;
         4'd3, 4'd8:  rails = 11'h060;
         4'd4, 4'd7:  rails = 11'h180;
         4'd5, 4'd6:  rails = 11'h600;
         default:     rails = '0;
      endcase
      return rails;
   endfunction

   // Number of the lowest set bit plus one, zero when none is set.
   function automatic logic [3:0] first_rail(input logic [RailCount-1:0] bad);
      logic [3:0] rail;
      rail = 4'd0;
      for (int i = RailCount - 1; i >= 0; i--) begin
         if (bad[i]) begin
            rail = 4'(i + 1);
         end
      end
      return rail;
   endfunction

endpackage

// ===== hw/rtl/sprs_csr.sv =====
module sprs_csr
   import sprs_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        psel,
   input  logic        penable,
   input  logic        pwrite,
   input  logic [2:0]  paddr,
   input  logic [31:0] pwdata,
   output logic [31:0] prdata,
   output cfg_type     cfg
);

   logic [15:0] delay_ff;
   logic [7:0]  board_ff;
   logic        write_en;

   assign write_en = psel && penable && pwrite;

   always_ff @(posedge clock) begin
      if (reset) begin
         delay_ff <= CHECK_DELAY_RESET;
         board_ff <= BOARD_ID_RESET;
      end else if (write_en) begin
         unique case (paddr[2])
            REG_CHECK_DELAY: delay_ff <= pwdata[15:0];
            REG_BOARD_ID:    board_ff <= pwdata[7:0];
            default:         ;
         endcase
      end
   end

   always_comb begin
      unique case (paddr[2])
         REG_CHECK_DELAY: prdata = {16'd0, delay_ff};
         REG_BOARD_ID:    prdata = {24'd0, board_ff};
         default:         prdata = '0;
      endcase
   end

   assign cfg.check_delay_ticks = delay_ff;
   assign cfg.board_identity    = board_ff;

endmodule

// ===== hw/rtl/sprs_seq.sv =====
module sprs_seq
   import sprs_pkg::*;
#(
   parameter int DELAY_BITS = 16
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       step,
   input  item_type   item,
   input  cfg_type    cfg,
   output result_type result
);

   localparam logic [32:0] DELAY_MAX = (33'(1) << DELAY_BITS) - 33'(1);

   logic [RailCount-1:0]  rails_ff, rails_in;
   logic                  osc_ff, osc_in;
   logic                  hold_ff, hold_in;
   logic                  ok_ff, ok_in;
   logic [3:0]            stage_ff, stage_in;
   logic                  rollback_ff, rollback_in;
   logic [DELAY_BITS-1:0] delay_ff, delay_in;

   logic [DELAY_BITS-1:0] delay_load;
   logic [3:0]            stage_now;
   logic                  enter;
   logic [3:0]            target;
   logic [RailCount-1:0]  want, bad;
   logic [3:0]            bad_rail;
   logic                  fault;

   // Saturate the programmed delay to the counter width.
   assign delay_load = (33'(cfg.check_delay_ticks) > DELAY_MAX) ? '1
                       : DELAY_BITS'(cfg.check_delay_ticks);

   // Codes above the last stage are treated as idle.
   assign stage_now = (stage_ff > STAGE_OFF_LAST) ? STAGE_IDLE : stage_ff;

   assign want     = (stage_now <= STAGE_ON_LAST) ? '1 : '0;
   assign bad      = (item.power_good ^ want) & stage_rails(stage_now);
   assign bad_rail = first_rail(bad);

   always_comb begin
      rails_in    = rails_ff;
      osc_in      = osc_ff;
      hold_in     = hold_ff;
      ok_in       = ok_ff;
      stage_in    = stage_now;
      rollback_in = (stage_ff > STAGE_OFF_LAST) ? 1'b0 : rollback_ff;
      delay_in    = delay_ff;
      enter       = 1'b0;
      target      = STAGE_IDLE;
      fault       = 1'b0;

      priority if (item.evaluate && item.host_power_enable && !ok_ff) begin
         rollback_in = 1'b0;
         enter       = 1'b1;
         target      = STAGE_ON_FIRST;
      end else if (item.evaluate && !item.host_power_enable && ok_ff) begin
         rollback_in = 1'b0;
         enter       = 1'b1;
         target      = STAGE_OFF_FIRST;
      end else if (stage_now != STAGE_IDLE) begin
         if (delay_ff != '0) begin
            delay_in = delay_ff - DELAY_BITS'(1);
         end else if (bad_rail != 4'd0) begin
            fault = 1'b1;
            if (stage_now <= STAGE_ON_LAST) begin
               rollback_in = 1'b1;
               enter       = 1'b1;
               target      = (stage_now <= STAGE_ON_EARLY) ? STAGE_RESET_HOLD
                             : STAGE_OFF_FIRST;
            end else begin
               stage_in    = STAGE_IDLE;
               rollback_in = 1'b0;
            end
         end else if (stage_now == STAGE_ON_LAST) begin
            ok_in    = 1'b1;
            stage_in = STAGE_IDLE;
         end else if (stage_now == STAGE_OFF_LAST) begin
            if (!rollback_in) begin
               ok_in = 1'b0;
            end
            rollback_in = 1'b0;
            stage_in    = STAGE_IDLE;
         end else begin
            enter  = 1'b1;
            target = stage_now + 4'd1;
         end
      end

      if (enter) begin
         stage_in = target;
         delay_in = delay_load;
         if (target <= STAGE_ON_LAST) begin
            rails_in = rails_ff | stage_rails(target);
            if (target == STAGE_ON_FIRST) begin
               osc_in = 1'b1;
            end
         end else begin
            rails_in = rails_ff & ~stage_rails(target);
            if (target == STAGE_RESET_HOLD) begin
               hold_in = 1'b1;
            end
            if (target == STAGE_OFF_LAST) begin
               osc_in = 1'b0;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rails_ff    <= '0;
         osc_ff      <= 1'b0;
         hold_ff     <= 1'b0;
         ok_ff       <= 1'b0;
         stage_ff    <= STAGE_IDLE;
         rollback_ff <= 1'b0;
         delay_ff    <= '0;
      end else if (step) begin
         rails_ff    <= rails_in;
         osc_ff      <= osc_in;
         hold_ff     <= hold_in;
         ok_ff       <= ok_in;
         stage_ff    <= stage_in;
         rollback_ff <= rollback_in;
         delay_ff    <= delay_in;
      end
   end

   assign result.rail_enables     = rails_in;
   assign result.osc_enable       = osc_in;
   assign result.reset_hold       = hold_in;
   assign result.card_power_ok    = ok_in;
   assign result.busy_res         = (stage_in != STAGE_IDLE);
   assign result.sequence_stage   = stage_in;
   assign result.fault_valid      = fault;
   assign result.fault_during_off = fault && (stage_now >= STAGE_OFF_FIRST);
   assign result.fault_rail       = fault ? bad_rail : 4'd0;
   assign result.fault_board      = fault ? cfg.board_identity : 8'd0;

   // Reset hold is released only by reset.
   a_hold_sticky: assert property (@(posedge clock) disable iff (reset)
      hold_ff |=> hold_ff) else $error("reset hold released");

   // The stage register never leaves the defined range.
   a_stage_range: assert property (@(posedge clock) disable iff (reset)
      stage_ff <= STAGE_OFF_LAST) else $error("stage code out of range");

   // A rollback only runs through the off stages.
   a_rollback_off: assert property (@(posedge clock) disable iff (reset)
      rollback_ff |-> stage_ff >= STAGE_OFF_FIRST) else $error("rollback outside off stages");

endmodule

// ===== hw/rtl/staged_power_rail_sequencer.sv =====
// Staged power rail sequencer.
// Each transfer on the req_ channel is one time tick: the host power request level, an
// evaluate strobe and the eleven power-good pin levels. For every request transfer the
// block returns exactly one transfer on the rsp_ channel carrying the rail enables,
// oscillator enable, reset hold, card power-ok flag, current stage and any fault event
// raised by this tick's power-good check.
// The check delay and board identity are written through the APB-style control port
// (register 0 at address 0, register 1 at address 4); write them only while no tick
// is outstanding.
// A tick is taken into the input register, evaluated from there, and its response is
// registered in the output register. One tick per cycle is sustained while the receiver
// does not stall; the rate rests on the combinational next-state logic of the sequencer.
// When the receiver stalls, the response waits in the output register, one further
// tick waits in the input register, and req_ready then drops until the output drains.
// Synchronous reset empties both registers, returns all rails, the oscillator and the
// reset hold to off, clears the card power-ok flag and restores the register defaults
// (check delay 100 ticks, board identity 0).
module staged_power_rail_sequencer
   import sprs_pkg::*;
#(
   parameter int DELAY_BITS = 16
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic        req_host_power_enable,
   input  logic        req_evaluate,
   input  logic [10:0] req_power_good,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [10:0] rsp_rail_enables,
   output logic        rsp_osc_enable,
   output logic        rsp_reset_hold,
   output logic        rsp_card_power_ok,
   output logic        rsp_busy_res,
   output logic [3:0]  rsp_sequence_stage,
   output logic        rsp_fault_valid,
   output logic        rsp_fault_during_off,
   output logic [3:0]  rsp_fault_rail,
   output logic [7:0]  rsp_fault_board,
   input  logic        psel,
   input  logic        penable,
   input  logic        pwrite,
   input  logic [2:0]  paddr,
   input  logic [31:0] pwdata,
   output logic [31:0] prdata,
   output logic        pready
);

   cfg_type    cfg;
   item_type   item_ff, item_in;
   logic       in_valid_ff, in_valid_in;
   result_type result_ff, result_in;
   logic       out_valid_ff, out_valid_in;
   logic       advance;
   logic       req_take;

   // The control port never waits.
   assign pready = 1'b1;

   sprs_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .cfg     (cfg)
   );

   // The held tick is evaluated whenever the output register is free or is being
   // emptied in this cycle; the sequencer state moves on only then.
   assign advance   = in_valid_ff && (!out_valid_ff || rsp_ready);
   assign req_ready = !in_valid_ff || advance;
   assign req_take  = req_valid && req_ready;

   assign item_in.host_power_enable = req_host_power_enable;
   assign item_in.evaluate          = req_evaluate;
   assign item_in.power_good        = req_power_good;

   sprs_seq #(
      .DELAY_BITS (DELAY_BITS)
   ) u_seq (
      .clock  (clock),
      .reset  (reset),
      .step   (advance),
      .item   (item_ff),
      .cfg    (cfg),
      .result (result_in)
   );

   always_comb begin
      in_valid_in  = req_take ? 1'b1 : (advance ? 1'b0 : in_valid_ff);
      out_valid_in = advance ? 1'b1 : (rsp_ready ? 1'b0 : out_valid_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // Payload registers carry no reset; their valid flags guard them.
   always_ff @(posedge clock) begin
      if (req_take) begin
         item_ff <= item_in;
      end
      if (advance) begin
         result_ff <= result_in;
      end
   end

   assign rsp_valid            = out_valid_ff;
   assign rsp_rail_enables     = result_ff.rail_enables;
   assign rsp_osc_enable       = result_ff.osc_enable;
   assign rsp_reset_hold       = result_ff.reset_hold;
   assign rsp_card_power_ok    = result_ff.card_power_ok;
   assign rsp_busy_res         = result_ff.busy_res;
   assign rsp_sequence_stage   = result_ff.sequence_stage;
   assign rsp_fault_valid      = result_ff.fault_valid;
   assign rsp_fault_during_off = result_ff.fault_during_off;
   assign rsp_fault_rail       = result_ff.fault_rail;
   assign rsp_fault_board      = result_ff.fault_board;

   // The busy flag agrees with the reported stage.
   a_busy_stage: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_busy_res == (rsp_sequence_stage != STAGE_IDLE)))
      else $error("busy flag disagrees with stage");

   // A fault names a real rail; without a fault the event fields are clear.
   a_fault_rail: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_fault_valid |-> (rsp_fault_rail != 4'd0) && (rsp_fault_rail <= 4'd11))
      else $error("fault rail out of range");

   a_fault_clear: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_fault_valid |->
         !rsp_fault_during_off && (rsp_fault_rail == 4'd0) && (rsp_fault_board == 8'd0))
      else $error("fault fields set without a fault");

   // A stalled response and a held tick together block new requests.
   a_full_blocks: assert property (@(posedge clock) disable iff (reset)
      in_valid_ff && out_valid_ff && !rsp_ready |-> !req_ready)
      else $error("request taken while both registers are full");

endmodule

// ===== test/tb.sv =====
module tb;
   import sprs_pkg::*;

   // Rails switched, and later checked, by each stage. The on stages raise their rails,
   // the off stages lower the same groups in the reverse order, and the final off stage
   // only stops the oscillator, so it has no pins to check.
   localparam logic [10:0] RAILS_BY_STAGE [12] = '{
      11'h000, 11'h007, 11'h018, 11'h060, 11'h180, 11'h600,
      11'h600, 11'h180, 11'h060, 11'h018, 11'h007, 11'h000
   };
   localparam logic [10:0] ALL_RAILS = 11'h7FF;
   localparam int unsigned IDLE_LIMIT = 2000;
   localparam int unsigned LONG_HOLD_AT = 150;
   localparam int unsigned LONG_HOLD_CYCLES = 80;

   // Short opening run, one entry per tick as {host request, evaluate, power-good pins}.
   // It starts with the check delay at zero, so every stage is checked on the tick after
   // it is entered.
   localparam item_type OPENING_TICKS [30] = '{
      {1'b1, 1'b1, 11'h000},      // ask for power: power-on starts
      {1'b0, 1'b1, ALL_RAILS},    // evaluate that changes nothing; the sequence goes on
      {1'b1, 1'b1, ALL_RAILS},    // evaluate while running: power-on is started again
      {1'b1, 1'b0, ALL_RAILS},
      {1'b1, 1'b0, ALL_RAILS},
      {1'b1, 1'b0, ALL_RAILS},
      {1'b1, 1'b0, ALL_RAILS},
      {1'b1, 1'b0, ALL_RAILS},    // last on stage passes: card power ok
      {1'b1, 1'b1, 11'h000},      // power requested while already ok: ignored
      {1'b0, 1'b1, ALL_RAILS},    // power-off starts
      {1'b0, 1'b0, 11'h000},
      {1'b0, 1'b0, 11'h000},
      {1'b0, 1'b0, 11'h000},      // resets held from here on
      {1'b0, 1'b0, 11'h000},
      {1'b0, 1'b0, 11'h000},
      {1'b0, 1'b0, ALL_RAILS},    // oscillator stage checks no pins: card power ok clears
      {1'b1, 1'b1, ALL_RAILS},
      {1'b1, 1'b0, 11'h7FD},      // rail 2 fails early: roll back from the reset-hold stage
      {1'b1, 1'b0, 11'h000},
      {1'b1, 1'b0, 11'h001},      // rail 1 still high during the rollback: it stops there
      {1'b1, 1'b1, 11'h000},
      {1'b1, 1'b0, ALL_RAILS},
      {1'b1, 1'b0, ALL_RAILS},
      {1'b1, 1'b0, 11'h7BF},      // rail 7 fails late: roll back from the first off stage
      {1'b1, 1'b0, 11'h000},
      {1'b1, 1'b0, 11'h000},
      {1'b1, 1'b0, 11'h000},
      {1'b1, 1'b0, 11'h000},
      {1'b1, 1'b0, 11'h000},
      {1'b1, 1'b0, 11'h000}       // rollback ends with card power ok left as it was
   };

   // Tracks the sequencer tick by tick and holds the status transfers still owed.
   class rail_sequence_checker;
      logic [15:0] check_delay;
      logic [7:0]  board_id;
      logic [10:0] rails;
      logic        osc;
      logic        hold;
      logic        card_ok;
      logic        rolling;
      logic [3:0]  stage;
      logic [15:0] countdown;
      result_type  owed_status [$];
      int unsigned failures;
      int unsigned checked;

      function new();
         check_delay = CHECK_DELAY_RESET;
         board_id    = BOARD_ID_RESET;
         rails       = '0;
         osc         = 1'b0;
         hold        = 1'b0;
         card_ok     = 1'b0;
         rolling     = 1'b0;
         stage       = STAGE_IDLE;
         countdown   = '0;
         failures    = 0;
         checked     = 0;
      endfunction

      function int unsigned pending();
         return owed_status.size();
      endfunction

      // Pin levels that pass the check of the stage now in progress; other pins are noise.
      function logic [10:0] matching_levels(input logic [10:0] noise);
         if (stage >= STAGE_ON_FIRST && stage <= STAGE_ON_LAST) begin
            return noise | RAILS_BY_STAGE[stage];
         end
         if (stage >= STAGE_OFF_FIRST && stage <= STAGE_OFF_LAST) begin
            return noise & ~RAILS_BY_STAGE[stage];
         end
         return noise;
      endfunction

      function void switch_to(input logic [3:0] next);
         stage     = next;
         countdown = check_delay;
         if (next >= STAGE_ON_FIRST && next <= STAGE_ON_LAST) begin
            rails = rails | RAILS_BY_STAGE[next];
            if (next == STAGE_ON_FIRST) osc = 1'b1;
         end else if (next >= STAGE_OFF_FIRST && next <= STAGE_OFF_LAST) begin
            rails = rails & ~RAILS_BY_STAGE[next];
            if (next == STAGE_RESET_HOLD) hold = 1'b1;
            if (next == STAGE_OFF_LAST) osc = 1'b0;
         end
      endfunction

      function void note_tick(input item_type tick);
         result_type  status;
         logic [10:0] wrong;
         logic [3:0]  rail;
         status = '0;
         if (stage > STAGE_OFF_LAST) begin
            stage   = STAGE_IDLE;
            rolling = 1'b0;
         end
         if (tick.evaluate && tick.host_power_enable && !card_ok) begin
            rolling = 1'b0;
            switch_to(STAGE_ON_FIRST);
         end else if (tick.evaluate && !tick.host_power_enable && card_ok) begin
            rolling = 1'b0;
            switch_to(STAGE_OFF_FIRST);
         end else if (stage != STAGE_IDLE) begin
            if (countdown != 0) begin
               countdown = countdown - 1'b1;
            end else begin
               if (stage <= STAGE_ON_LAST) wrong = ~tick.power_good & RAILS_BY_STAGE[stage];
               else wrong = tick.power_good & RAILS_BY_STAGE[stage];
               rail = '0;
               for (int i = 0; i < 11; i++) begin
                  if (wrong[i] && rail == 0) rail = 4'(i + 1);
               end
               if (rail != 0) begin
                  status.fault_valid      = 1'b1;
                  status.fault_during_off = (stage >= STAGE_OFF_FIRST);
                  status.fault_rail       = rail;
                  status.fault_board      = board_id;
                  if (stage <= STAGE_ON_LAST) begin
                     rolling = 1'b1;
                     if (stage <= STAGE_ON_EARLY) switch_to(STAGE_RESET_HOLD);
                     else switch_to(STAGE_OFF_FIRST);
                  end else begin
                     stage   = STAGE_IDLE;
                     rolling = 1'b0;
                  end
               end else if (stage == STAGE_ON_LAST) begin
                  card_ok = 1'b1;
                  stage   = STAGE_IDLE;
               end else if (stage == STAGE_OFF_LAST) begin
                  if (!rolling) card_ok = 1'b0;
                  rolling = 1'b0;
                  stage   = STAGE_IDLE;
               end else begin
                  switch_to(4'(stage + 1));
               end
            end
         end
         status.rail_enables   = rails;
         status.osc_enable     = osc;
         status.reset_hold     = hold;
         status.card_power_ok  = card_ok;
         status.busy_res       = (stage != STAGE_IDLE);
         status.sequence_stage = stage;
         owed_status.push_back(status);
      endfunction

      task report(input string msg);
         if (failures < 30) $display("mismatch: %s", msg);
         failures++;
      endtask

      task compare(input string field, input logic [15:0] got, input logic [15:0] want);
         if (got !== want) begin
            report($sformatf("status %0d %s is %0h, predicted %0h", checked, field, got, want));
         end
      endtask

      task check_status(input result_type got);
         result_type want;
         if (owed_status.size() == 0) begin
            report($sformatf("status transfer %0d arrived with no tick outstanding", checked));
         end else begin
            want = owed_status.pop_front();
            compare("rail_enables", 16'(got.rail_enables), 16'(want.rail_enables));
            compare("osc_enable", 16'(got.osc_enable), 16'(want.osc_enable));
            compare("reset_hold", 16'(got.reset_hold), 16'(want.reset_hold));
            compare("card_power_ok", 16'(got.card_power_ok), 16'(want.card_power_ok));
            compare("busy_res", 16'(got.busy_res), 16'(want.busy_res));
            compare("sequence_stage", 16'(got.sequence_stage), 16'(want.sequence_stage));
            compare("fault_valid", 16'(got.fault_valid), 16'(want.fault_valid));
            compare("fault_during_off", 16'(got.fault_during_off),
                    16'(want.fault_during_off));
            compare("fault_rail", 16'(got.fault_rail), 16'(want.fault_rail));
            compare("fault_board", 16'(got.fault_board), 16'(want.fault_board));
         end
         checked++;
      endtask
   endclass

   logic        clock;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   logic        req_host_power_enable = 1'b0;
   logic        req_evaluate = 1'b0;
   logic [10:0] req_power_good = '0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   logic [10:0] rsp_rail_enables;
   logic        rsp_osc_enable;
   logic        rsp_reset_hold;
   logic        rsp_card_power_ok;
   logic        rsp_busy_res;
   logic [3:0]  rsp_sequence_stage;
   logic        rsp_fault_valid;
   logic        rsp_fault_during_off;
   logic [3:0]  rsp_fault_rail;
   logic [7:0]  rsp_fault_board;
   logic        psel = 1'b0;
   logic        penable = 1'b0;
   logic        pwrite = 1'b0;
   logic [2:0]  paddr = '0;
   logic [31:0] pwdata = '0;
   logic [31:0] prdata;
   logic        pready;

   // When set, neither side inserts idle cycles, so the block runs at one tick per cycle.
   bit steady = 1'b0;

   rail_sequence_checker sb = new();

   staged_power_rail_sequencer i_dut (
      .clock                (clock),
      .reset                (reset),
      .req_valid            (req_valid),
      .req_ready            (req_ready),
      .req_host_power_enable(req_host_power_enable),
      .req_evaluate         (req_evaluate),
      .req_power_good       (req_power_good),
      .rsp_valid            (rsp_valid),
      .rsp_ready            (rsp_ready),
      .rsp_rail_enables     (rsp_rail_enables),
      .rsp_osc_enable       (rsp_osc_enable),
      .rsp_reset_hold       (rsp_reset_hold),
      .rsp_card_power_ok    (rsp_card_power_ok),
      .rsp_busy_res         (rsp_busy_res),
      .rsp_sequence_stage   (rsp_sequence_stage),
      .rsp_fault_valid      (rsp_fault_valid),
      .rsp_fault_during_off (rsp_fault_during_off),
      .rsp_fault_rail       (rsp_fault_rail),
      .rsp_fault_board      (rsp_fault_board),
      .psel                 (psel),
      .penable              (penable),
      .pwrite               (pwrite),
      .paddr                (paddr),
      .pwdata               (pwdata),
      .prdata               (prdata),
      .pready               (pready)
   );

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   // Idle stretch length: usually none, sometimes a short one, now and then a long one.
   function automatic int unsigned gap_len(input int unsigned busy_pct);
      int unsigned roll;
      roll = $urandom_range(0, 99);
      if (roll >= busy_pct) return 0;
      if (roll * 8 < busy_pct * 7) return $urandom_range(1, 3);
      return $urandom_range(8, 30);
   endfunction

   // Offers one tick and holds it until the block takes it. The valid is left high, so
   // that a following tick can go out on the very next cycle without a bubble; callers
   // lower it explicitly when a pause follows.
   task automatic send_tick(input item_type tick);
      req_valid             <= 1'b1;
      req_host_power_enable <= tick.host_power_enable;
      req_evaluate          <= tick.evaluate;
      req_power_good        <= tick.power_good;
      do @(posedge clock); while (!req_ready);
      sb.note_tick(tick);
   endtask

   task automatic sender_gap();
      int unsigned idle;
      idle = steady ? 0 : gap_len(30);
      if (idle != 0) begin
         req_valid <= 1'b0;
         repeat (idle) @(posedge clock);
      end
   endtask

   // Stops offering ticks and waits until every status transfer owed has come back and a
   // guard wait has passed, so that the registers may then be rewritten safely.
   task automatic settle();
      req_valid <= 1'b0;
      do @(posedge clock); while (sb.pending() != 0);
      repeat (2) @(posedge clock);
   endtask

   // Setup cycle, then the access cycle; the register takes the data at the edge that
   // closes the access phase. The predictor picks up the new value at the same point.
   task automatic csr_write(input logic reg_sel, input logic [31:0] data);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= {reg_sel, 2'b00};
      pwdata  <= data;
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      if (reg_sel == REG_CHECK_DELAY) sb.check_delay = data[15:0];
      else sb.board_id = data[7:0];
      psel    <= 1'b0;
      penable <= 1'b0;
      pwrite  <= 1'b0;
      @(posedge clock);
   endtask

   task automatic configure(input logic [15:0] delay, input logic [7:0] board);
      settle();
      csr_write(REG_CHECK_DELAY, 32'(delay));
      csr_write(REG_BOARD_ID, 32'(board));
   endtask

   // A burst of random ticks. It opens with an evaluate that is sure to start a sequence,
   // and after that the power-good pins mostly show the levels that the stage in progress
   // expects, so that sequences usually run to the end; the remaining ticks carry noise
   // on the pins and produce faults. The host request level changes only now and then,
   // and evaluate strobes are rare, so most strobes land in the middle of a sequence.
   task automatic random_ticks(input int unsigned count);
      item_type    tick;
      logic        host_level;
      logic [10:0] noise;
      host_level             = !sb.card_ok;
      tick.host_power_enable = host_level;
      tick.evaluate          = 1'b1;
      tick.power_good        = 11'($urandom_range(0, 2047));
      send_tick(tick);
      repeat (count) begin
         sender_gap();
         if ($urandom_range(0, 99) < 5) host_level = !host_level;
         noise                  = 11'($urandom_range(0, 2047));
         tick.host_power_enable = host_level;
         tick.evaluate          = ($urandom_range(0, 99) < 4);
         tick.power_good        = ($urandom_range(0, 99) < 90) ? sb.matching_levels(noise)
                                                               : noise;
         send_tick(tick);
      end
   endtask

   // Stimulus. The first burst runs with the register defaults, where the long check
   // delay keeps every sequence waiting in its first stage. Then the opening run walks a
   // clean power-on and power-off, an abort and both kinds of rollback with no delay.
   // The remaining bursts step through several delays and board identities, including
   // both ends of each range; the longest delay gets only a few ticks, since no check
   // can be reached with it.
   initial begin
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      random_ticks(40);

      configure(16'd0, 8'hFF);
      foreach (OPENING_TICKS[i]) begin
         send_tick(OPENING_TICKS[i]);
         if (i != $size(OPENING_TICKS) - 1) sender_gap();
      end
      settle();
      random_ticks(150);

      configure(16'd1, 8'hA5);
      steady = 1'b1;
      random_ticks(150);
      steady = 1'b0;

      configure(16'd2, 8'h00);
      random_ticks(120);

      configure(16'hFFFF, 8'($urandom_range(0, 255)));
      random_ticks(20);

      configure(16'd3, 8'($urandom_range(0, 255)));
      random_ticks(150);

      configure(16'd0, 8'($urandom_range(0, 255)));
      random_ticks(120);

      settle();
      repeat (4) @(posedge clock);
      if (sb.failures == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

   // Response side. Each status transfer taken is checked against the oldest owed one.
   // The ready is dropped for random stretches, except in the steady burst. Once, after a
   // fixed number of transfers, it is held low for a long stretch while the sender keeps
   // offering ticks, so that both internal registers fill and the block stalls its input.
   initial begin : status_sink
      int unsigned stall_left;
      bit          long_hold_done;
      result_type  seen;
      stall_left     = 0;
      long_hold_done = 1'b0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_valid && rsp_ready) begin
            seen.rail_enables     = rsp_rail_enables;
            seen.osc_enable       = rsp_osc_enable;
            seen.reset_hold       = rsp_reset_hold;
            seen.card_power_ok    = rsp_card_power_ok;
            seen.busy_res         = rsp_busy_res;
            seen.sequence_stage   = rsp_sequence_stage;
            seen.fault_valid      = rsp_fault_valid;
            seen.fault_during_off = rsp_fault_during_off;
            seen.fault_rail       = rsp_fault_rail;
            seen.fault_board      = rsp_fault_board;
            sb.check_status(seen);
         end
         if (!long_hold_done && sb.checked == LONG_HOLD_AT) begin
            stall_left     = LONG_HOLD_CYCLES;
            long_hold_done = 1'b1;
         end else if (stall_left == 0 && !steady) begin
            stall_left = gap_len(25);
         end
         if (stall_left != 0) begin
            rsp_ready <= 1'b0;
            stall_left--;
         end else begin
            rsp_ready <= 1'b1;
         end
      end
   end

   // Watchdog: any transfer on either channel restarts the count of quiet cycles.
   int unsigned quiet_cycles = 0;

   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= IDLE_LIMIT) begin
         $display("watchdog: no transfer for %0d cycles, %0d status transfers owed",
                  quiet_cycles, sb.pending());
         $display("[FAIL] regression broken");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

endmodule
